>>> hw/rtl/gpgi_pkg.sv
// Shared types and constants for the GF(2) polynomial gcd and inverse core.
`default_nettype none

package gpgi_pkg;

   // Width of every polynomial field on the ports.
   localparam int FIELD_BITS = 32;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE     = 4'd0,
      OP_LOAD     = 4'd1,
      OP_SHIFT_B  = 4'd2,
      OP_SHIFT_A  = 4'd3,
      OP_DIV_STEP = 4'd4,
      OP_DIV_LAST = 4'd5,
      OP_SHIFT_R  = 4'd6,
      OP_SWAP     = 4'd7,
      OP_ALIGN    = 4'd8
   } op_type;

   typedef struct packed {
      op_type op;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic a_top;
      logic a_zero;
      logic b_top;
      logic b_zero;
      logic pos_gt_db;
      logic pos_lt_db;
      logic db_full;
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/gpgi_dp.sv
// Datapath: left-aligned remainder pair, cofactors and the result register.
`default_nettype none

module gpgi_dp #(
   parameter int POLY_BITS = 32
) (
   input  wire                               clock,
   input  wire gpgi_pkg::cmd_type            cmd,
   output gpgi_pkg::status_type              status,
   input  wire [gpgi_pkg::FIELD_BITS-1:0]    req_poly_value,
   input  wire [gpgi_pkg::FIELD_BITS-1:0]    req_poly_modulus,
   output logic [gpgi_pkg::FIELD_BITS-1:0]   rsp_gcd_poly,
   output logic [gpgi_pkg::FIELD_BITS-1:0]   rsp_inverse_poly,
   output logic                              rsp_invertible
);

   localparam int W  = POLY_BITS;
   localparam int PW = $clog2(W);
   localparam int FB = gpgi_pkg::FIELD_BITS;

   // The remainders are kept with their leading term in the top bit; pos_ff and
   // db_ff hold the degree that the top bit of a_ff and b_ff stands for.
   logic [W-1:0]  a_ff, a_in, b_ff, b_in;
   logic [W-1:0]  u_ff, u_in, v_ff, v_in, vs_ff, vs_in;
   logic [PW-1:0] pos_ff, pos_in, db_ff, db_in;
   logic          mod_zero_ff, mod_zero_in, mod_one_ff, mod_one_in;
   logic [FB-1:0] gcd_ff, gcd_in, inv_ff, inv_in;
   logic          ok_ff, ok_in;

   logic [W-1:0]  val_w, mod_w, a_red, u_red;
   logic          gcd_one;

   always_comb begin
      val_w   = W'(req_poly_value);
      mod_w   = W'(req_poly_modulus);
      // One step of long division: cancel the leading term when it is set.
      a_red   = a_ff[W-1] ? (a_ff ^ b_ff) : a_ff;
      u_red   = a_ff[W-1] ? (u_ff ^ vs_ff) : u_ff;
      gcd_one = (b_ff == W'(1));

      a_in        = a_ff;
      b_in        = b_ff;
      u_in        = u_ff;
      v_in        = v_ff;
      vs_in       = vs_ff;
      pos_in      = pos_ff;
      db_in       = db_ff;
      mod_zero_in = mod_zero_ff;
      mod_one_in  = mod_one_ff;

      unique case (cmd.op)
         gpgi_pkg::OP_LOAD: begin
            a_in        = mod_w;
            b_in        = val_w;
            u_in        = '0;
            v_in        = W'(1);
            vs_in       = W'(1);
            pos_in      = PW'(W-1);
            db_in       = PW'(W-1);
            mod_zero_in = (mod_w == '0);
            mod_one_in  = (mod_w == W'(1));
         end
         gpgi_pkg::OP_SHIFT_B: begin
            b_in  = b_ff << 1;
            db_in = db_ff - PW'(1);
            vs_in = vs_ff << 1;
         end
         gpgi_pkg::OP_SHIFT_A: begin
            a_in   = a_ff << 1;
            pos_in = pos_ff - PW'(1);
            vs_in  = vs_ff >> 1;
         end
         gpgi_pkg::OP_DIV_STEP: begin
            a_in   = a_red << 1;
            u_in   = u_red;
            vs_in  = vs_ff >> 1;
            pos_in = pos_ff - PW'(1);
         end
         gpgi_pkg::OP_DIV_LAST: begin
            // The new cofactor is pre-shifted here and during renormalization of
            // the remainder, so it is aligned for the next division.
            a_in   = a_red << 1;
            u_in   = u_red;
            vs_in  = u_red << 1;
            pos_in = db_ff - PW'(1);
         end
         gpgi_pkg::OP_SHIFT_R: begin
            a_in   = a_ff << 1;
            pos_in = pos_ff - PW'(1);
            vs_in  = vs_ff << 1;
         end
         gpgi_pkg::OP_SWAP: begin
            a_in   = b_ff;
            b_in   = a_ff;
            pos_in = db_ff;
            db_in  = pos_ff;
            u_in   = v_ff;
            v_in   = u_ff;
         end
         gpgi_pkg::OP_ALIGN: begin
            b_in  = b_ff >> 1;
            db_in = db_ff + PW'(1);
         end
         default: begin
         end
      endcase

      gcd_in = gcd_ff;
      inv_in = inv_ff;
      ok_in  = ok_ff;
      if (cmd.out_load) begin
         gcd_in = FB'(b_ff);
         ok_in  = gcd_one && !mod_zero_ff;
         // Every residue modulo one is zero.
         inv_in = (gcd_one && !mod_zero_ff && !mod_one_ff) ? FB'(v_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      vs_ff       <= vs_in;
      pos_ff      <= pos_in;
      db_ff       <= db_in;
      mod_zero_ff <= mod_zero_in;
      mod_one_ff  <= mod_one_in;
      gcd_ff      <= gcd_in;
      inv_ff      <= inv_in;
      ok_ff       <= ok_in;
   end

   always_comb begin
      status.a_top     = a_ff[W-1];
      status.a_zero    = (a_ff == '0);
      status.b_top     = b_ff[W-1];
      status.b_zero    = (b_ff == '0);
      status.pos_gt_db = (pos_ff > db_ff);
      status.pos_lt_db = (pos_ff < db_ff);
      status.db_full   = (db_ff == PW'(W-1));
   end

   assign rsp_gcd_poly     = gcd_ff;
   assign rsp_inverse_poly = inv_ff;
   assign rsp_invertible   = ok_ff;

endmodule

`default_nettype wire

>>> hw/rtl/gpgi_ctrl.sv
// Controller state machine that sequences the extended Euclid datapath.
`default_nettype none

module gpgi_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   input  wire gpgi_pkg::status_type status,
   output gpgi_pkg::cmd_type         cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_START  = 8'b0000_0010,
      ST_NORMB  = 8'b0000_0100,
      ST_NORMA  = 8'b0000_1000,
      ST_DIV    = 8'b0001_0000,
      ST_NORMR  = 8'b0010_0000,
      ST_UNNORM = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = gpgi_pkg::OP_NONE;
      cmd.out_load = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = gpgi_pkg::OP_LOAD;
               state_in = ST_START;
            end
         end
         ST_START: begin
            // A zero operand makes the other operand the gcd at once.
            if (status.a_zero) begin
               state_in = ST_DONE;
            end else if (status.b_zero) begin
               cmd.op   = gpgi_pkg::OP_SWAP;
               state_in = ST_DONE;
            end else begin
               state_in = ST_NORMB;
            end
         end
         ST_NORMB: begin
            if (status.b_top) begin
               state_in = ST_NORMA;
            end else begin
               cmd.op = gpgi_pkg::OP_SHIFT_B;
            end
         end
         ST_NORMA: begin
            if (status.a_top) begin
               // A value of higher degree than the modulus gives a zero quotient.
               if (status.pos_lt_db) begin
                  cmd.op = gpgi_pkg::OP_SWAP;
               end
               state_in = ST_DIV;
            end else begin
               cmd.op = gpgi_pkg::OP_SHIFT_A;
            end
         end
         ST_DIV: begin
            if (status.pos_gt_db) begin
               cmd.op = gpgi_pkg::OP_DIV_STEP;
            end else begin
               cmd.op   = gpgi_pkg::OP_DIV_LAST;
               state_in = ST_NORMR;
            end
         end
         ST_NORMR: begin
            if (status.a_zero) begin
               state_in = ST_UNNORM;
            end else if (status.a_top) begin
               cmd.op   = gpgi_pkg::OP_SWAP;
               state_in = ST_DIV;
            end else begin
               cmd.op = gpgi_pkg::OP_SHIFT_R;
            end
         end
         ST_UNNORM: begin
            if (status.db_full) begin
               state_in = ST_DONE;
            end else begin
               cmd.op = gpgi_pkg::OP_ALIGN;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> hw/rtl/gf2_poly_gcd_inverse_core.sv
// After acceptance, the controller loads the operands, normalizes value and modulus so that the
// leading term of each stands in the top bit, then runs the divisions, taking one quotient bit
// and one remainder shift at a time with a swap before each further division, and finally
// right-aligns the gcd. One transaction at a time: a new one is accepted only once the last
// has left the datapath, even while its result still waits to be taken.
// Synchronous active-high reset returns the controller to idle with no result pending.
`default_nettype none

module gf2_poly_gcd_inverse_core #(
   parameter int POLY_BITS = 32
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire [gpgi_pkg::FIELD_BITS-1:0]   req_poly_value,
   input  wire [gpgi_pkg::FIELD_BITS-1:0]   req_poly_modulus,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [gpgi_pkg::FIELD_BITS-1:0]  rsp_gcd_poly,
   output logic [gpgi_pkg::FIELD_BITS-1:0]  rsp_inverse_poly,
   output logic                             rsp_invertible
);

   gpgi_pkg::cmd_type    cmd;
   gpgi_pkg::status_type status;

   gpgi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gpgi_dp #(
      .POLY_BITS (POLY_BITS)
   ) u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .req_poly_value   (req_poly_value),
      .req_poly_modulus (req_poly_modulus),
      .rsp_gcd_poly     (rsp_gcd_poly),
      .rsp_inverse_poly (rsp_inverse_poly),
      .rsp_invertible   (rsp_invertible)
   );

   // The core is busy right after it takes a transaction.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input ready stayed high after an accepted transaction");

   a_invertible_gcd_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invertible) |-> (rsp_gcd_poly == gpgi_pkg::FIELD_BITS'(1)))
      else $error("invertible result with a gcd other than one");

   a_no_inverse_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_invertible) |-> (rsp_inverse_poly == '0))
      else $error("nonzero inverse on a non-invertible result");

endmodule

`default_nettype wire
